// File: src/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants for the key matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

  localparam int unsigned HoldW      = 8;
  localparam int unsigned EnableW    = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned ColsW      = 4;
  localparam int unsigned DriveW     = 4;
  localparam int unsigned KeyFieldW  = 16;

  localparam logic [HoldW-1:0] HoldLimitReset = 8'd24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHoldEnable = 2'd0,
    CfgHoldLimit  = 2'd1
  } cfg_reg_e;

  // Per-key control for one completed scan.
  typedef struct packed {
    logic pressed;
    logic held;
  } kms_lane_ctrl_t;

endpackage : kms_pkg

`default_nettype wire

// File: src/keypad_matrix_scanner_unit.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_unit
// A result is registered and is valid in the cycle after its row sample is transferred.
// Throughput: one row sample per cycle while the result side does not stall, set by the single result register.
// Reset: row 0 is taken as driven, key maps, hold counts and valid clear,
// hold_enable resets to 0 and hold_limit to 24; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_scanner_unit
  import kms_pkg::*;
#(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // Row sample channel.
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ColsW-1:0]     row_columns_i,
  // Result channel.
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DriveW-1:0]         row_drive_o,
  output logic                      scan_done_o,
  output logic [KeyFieldW-1:0]      key_events_o,
  output logic [KeyFieldW-1:0]      key_state_o
);

  localparam int unsigned KEYS = ROWS * COLS;
  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to an unknown index are dropped.
  // --------------------------------------------------------------------------
  logic [EnableW-1:0] hold_enable_q;
  logic [HoldW-1:0]   hold_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_enable_q <= '0;
      hold_limit_q  <= HoldLimitReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgHoldEnable) begin
        hold_enable_q <= cfg_data_i[EnableW-1:0];
      end else if (cfg_index_i == CfgHoldLimit) begin
        hold_limit_q <= cfg_data_i[HoldW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The result register is the only stage, so a new sample is
  // taken whenever the result register is empty or is being drained this
  // cycle. A stalled result therefore holds off the input side.
  // --------------------------------------------------------------------------
  logic accept;
  logic out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Scan state: the row being sampled, the map being gathered and the map of
  // the last completed scan.
  // --------------------------------------------------------------------------
  logic [RowW-1:0] row_q, row_d;
  logic [KEYS-1:0] current_keys_q, current_keys_d;
  logic [KEYS-1:0] previous_keys_q, previous_keys_d;

  // Column bits beyond COLS are dropped; missing columns read as released.
  logic [COLS+ColsW-1:0] cols_ext;
  logic [COLS-1:0]       cols;

  assign cols_ext = {{COLS{1'b0}}, row_columns_i};
  assign cols     = cols_ext[COLS-1:0];

  // The sample lands at bits row*COLS+col of the map.
  logic [KEYS-1:0] row_bits;
  logic [KEYS-1:0] now_keys;
  logic            last_row;

  always_comb begin
    row_bits = '0;
    for (int unsigned r = 0; r < ROWS; r++) begin
      if (row_q == RowW'(r)) begin
        row_bits[r*COLS +: COLS] = cols;
      end
    end
  end

  assign now_keys = current_keys_q | row_bits;
  assign last_row = (row_q == LastRow);

  // hold_enable covers only the first 16 keys; later keys never repeat.
  logic [KEYS+EnableW-1:0] enable_ext;
  logic [KEYS-1:0]         enable_keys;

  assign enable_ext  = {{KEYS{1'b0}}, hold_enable_q};
  assign enable_keys = enable_ext[KEYS-1:0];

  // Per-key comparison with the previous scan, only on the last row.
  logic [KEYS-1:0] pressed_keys;
  logic [KEYS-1:0] held_keys;
  logic [KEYS-1:0] released_keys;
  logic [KEYS-1:0] repeat_keys;
  logic            scan_step;

  assign scan_step     = accept && last_row;
  assign pressed_keys  = now_keys & ~previous_keys_q;
  assign released_keys = previous_keys_q & ~now_keys;
  assign held_keys     = now_keys & previous_keys_q & enable_keys;

  // One hold counter per key. A counter moves only on a completed scan.
  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    kms_lane_ctrl_t lane_ctrl;

    assign lane_ctrl.pressed = scan_step && pressed_keys[k];
    assign lane_ctrl.held    = scan_step && held_keys[k];

    kms_hold_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .hold_limit_i (hold_limit_q),
      .repeat_o     (repeat_keys[k])
    );
  end

  // Next scan state. After the last row the gathered map becomes the
  // previous map and scanning restarts at row 0.
  always_comb begin
    row_d           = row_q;
    current_keys_d  = current_keys_q;
    previous_keys_d = previous_keys_q;
    if (accept) begin
      if (last_row) begin
        row_d           = '0;
        current_keys_d  = '0;
        previous_keys_d = now_keys;
      end else begin
        row_d          = row_q + 1'b1;
        current_keys_d = now_keys;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q           <= '0;
      current_keys_q  <= '0;
      previous_keys_q <= '0;
    end else begin
      row_q           <= row_d;
      current_keys_q  <= current_keys_d;
      previous_keys_q <= previous_keys_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result fields. The row mask is one-hot for the next row, or every row
  // after a completed scan, cut to the four output bits. Key fields are the
  // first 16 keys; missing keys read as zero.
  // --------------------------------------------------------------------------
  logic [DriveW-1:0]         drive_next;
  logic [KEYS-1:0]           events_keys;
  logic [KEYS+KeyFieldW-1:0] events_ext;
  logic [KEYS+KeyFieldW-1:0] state_ext;

  always_comb begin
    for (int unsigned b = 0; b < DriveW; b++) begin
      if (last_row) begin
        drive_next[b] = (b < ROWS);
      end else begin
        drive_next[b] = ((int'(row_q) + 1) == int'(b));
      end
    end
  end

  assign events_keys = last_row ? (released_keys | repeat_keys) : '0;
  assign events_ext  = {{KeyFieldW{1'b0}}, events_keys};
  assign state_ext   = {{KeyFieldW{1'b0}}, previous_keys_d};

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic [DriveW-1:0]    row_drive_q;
  logic                 scan_done_q;
  logic [KeyFieldW-1:0] key_events_q;
  logic [KeyFieldW-1:0] key_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_drive_q  <= drive_next;
      scan_done_q  <= last_row;
      key_events_q <= events_ext[KeyFieldW-1:0];
      key_state_q  <= state_ext[KeyFieldW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_drive_o  = row_drive_q;
  assign scan_done_o  = scan_done_q;
  assign key_events_o = key_events_q;
  assign key_state_o  = key_state_q;

  function automatic logic [DriveW-1:0] drive_next_all();
    logic [DriveW-1:0] m;
    for (int unsigned b = 0; b < DriveW; b++) begin
      m[b] = (b < ROWS);
    end
    return m;
  endfunction

`ifndef SYNTHESIS
  // The row counter never walks past the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q <= LastRow)
    else $error("row index beyond last row");

  // A completed scan leaves an empty map for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_step |=> current_keys_q == '0)
    else $error("key map not cleared after scan");

  // Events appear only on a completing result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scan_done_o |-> key_events_o == '0)
    else $error("key events outside a completed scan");

  // A completing result drives every row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_step |=> row_drive_q == drive_next_all())
    else $error("row drive not all rows after scan");
`endif

endmodule : keypad_matrix_scanner_unit

`default_nettype wire

// File: src/kms_hold_lane.sv
// ----------------------------------------------------------------------------
// kms_hold_lane
// Hold counter of one key: counts held scans and flags a repeat event.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_hold_lane
  import kms_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire kms_lane_ctrl_t   ctrl_i,
  input  wire logic [HoldW-1:0] hold_limit_i,
  output logic                  repeat_o
);

  logic [HoldW-1:0] count_q, count_d;
  logic [HoldW-1:0] count_inc;

  always_comb begin
    count_inc = count_q + 1'b1;
    repeat_o  = ctrl_i.held && (count_inc > hold_limit_i);
    count_d   = count_q;
    if (ctrl_i.pressed) begin
      count_d = '0;
    end else if (ctrl_i.held) begin
      count_d = repeat_o ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule : kms_hold_lane

`default_nettype wire

// File: test/keypad_matrix_scanner_unit_tb.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_unit_tb
// Self-checking bench for the row-at-a-time key matrix scanner. Row samples
// are streamed in as whole scans, mostly of slowly changing key maps, so
// that held keys run their long-press counters up to and past the limit.
// A scoreboard keeps its own copy of the scanner state, predicts every
// result and compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kms_pkg::*;

  localparam int ScanRows = 4;
  localparam int ScanCols = 4;
  localparam int KeyCount = ScanRows * ScanCols;
  localparam logic [DriveW-1:0] AllRows = 4'b1111;

  // Indexes that map to no register; writes to them must leave state alone.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    logic [DriveW-1:0]    row_drive;
    logic                 scan_done;
    logic [KeyFieldW-1:0] key_events;
    logic [KeyFieldW-1:0] key_state;
  } scan_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the scanner state and queues the predicted results.
  // --------------------------------------------------------------------------
  class scan_scoreboard;
    logic [EnableW-1:0]   hold_enable;
    logic [HoldW-1:0]     hold_limit;
    logic [1:0]           row_idx;
    logic [KeyFieldW-1:0] cur_keys;
    logic [KeyFieldW-1:0] prev_keys;
    logic [HoldW-1:0]     hold_cnt [KeyCount];
    scan_result_t         expected_q [$];
    int                   errors;

    function new();
      hold_enable = '0;
      hold_limit  = HoldLimitReset;
      row_idx     = '0;
      cur_keys    = '0;
      prev_keys   = '0;
      foreach (hold_cnt[k]) hold_cnt[k] = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgHoldEnable) begin
        hold_enable = data;
      end else if (idx == CfgHoldLimit) begin
        hold_limit = data[HoldW-1:0];
      end
    endfunction

    // Called for every transfer on the row sample channel.
    function void note_row_sample(logic [ColsW-1:0] cols);
      scan_result_t         res;
      logic [KeyFieldW-1:0] changed;
      logic [KeyFieldW-1:0] pressed;
      logic [KeyFieldW-1:0] held;
      res = '0;
      cur_keys |= KeyFieldW'(cols) << (row_idx * ScanCols);
      if (row_idx == ScanRows - 1) begin
        changed = cur_keys ^ prev_keys;
        pressed = changed & cur_keys;
        held    = cur_keys & prev_keys & hold_enable;
        res.key_events = changed & prev_keys;
        for (int k = 0; k < KeyCount; k++) begin
          if (pressed[k]) hold_cnt[k] = '0;
          if (held[k]) begin
            hold_cnt[k] = hold_cnt[k] + 8'd1;
            if (hold_cnt[k] > hold_limit) begin
              res.key_events[k] = 1'b1;
              hold_cnt[k] = '0;
            end
          end
        end
        prev_keys     = cur_keys;
        cur_keys      = '0;
        row_idx       = '0;
        res.row_drive = AllRows;
        res.scan_done = 1'b1;
      end else begin
        row_idx       = row_idx + 2'd1;
        res.row_drive = DriveW'(1) << row_idx;
      end
      res.key_state = prev_keys;
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic [KeyFieldW-1:0] exp_v,
                         logic [KeyFieldW-1:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endfunction

    // Called for every transfer on the result channel.
    function void check_result(logic [DriveW-1:0] row_drive, logic scan_done,
                               logic [KeyFieldW-1:0] key_events,
                               logic [KeyFieldW-1:0] key_state);
      scan_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h %b %h %h", $time,
                 row_drive, scan_done, key_events, key_state);
      end else begin
        exp_r = expected_q.pop_front();
        if (row_drive !== exp_r.row_drive)   report("row_drive", exp_r.row_drive, row_drive);
        if (scan_done !== exp_r.scan_done)   report("scan_done", exp_r.scan_done, scan_done);
        if (key_events !== exp_r.key_events) report("key_events", exp_r.key_events, key_events);
        if (key_state !== exp_r.key_state)   report("key_state", exp_r.key_state, key_state);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ColsW-1:0]     row_columns_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DriveW-1:0]    row_drive_o;
  logic                 scan_done_o;
  logic [KeyFieldW-1:0] key_events_o;
  logic [KeyFieldW-1:0] key_state_o;

  // When set, neither side idles: the block runs at full rate.
  logic calm;
  int   stall_run;

  scan_scoreboard sb = new();

  keypad_matrix_scanner_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_columns_i (row_columns_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_drive_o   (row_drive_o),
    .scan_done_o   (scan_done_o),
    .key_events_o  (key_events_o),
    .key_state_o   (key_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("keypad_matrix_scanner_unit_tb: done, errors");
    $finish;
  end

  // Idle lengths: most are short, a few are long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 99) < 65) return 0;
    return pick_len();
  endfunction

  // Result side back-pressure. A stall run keeps out_stall_i high for its
  // whole length; a new run is only picked once the previous one is over.
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_run = pick_len();
    end
    out_stall_i <= (stall_run > 0);
  end

  // Every transfer on the result channel is checked against the oldest
  // prediction. All block outputs change on nonblocking updates, so the
  // values read here are the ones present just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(row_drive_o, scan_done_o, key_events_o, key_state_o);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Presents one row sample and returns at the edge of its transfer. Valid
  // only drops when a gap is inserted, so back-to-back samples keep it high.
  task automatic send_row(input logic [ColsW-1:0] cols);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    row_columns_i <= cols;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_row_sample(cols);
  endtask

  // One full scan of a key map, row 0 first.
  task automatic send_scan(input logic [KeyFieldW-1:0] key_map);
    for (int r = 0; r < ScanRows; r++) begin
      send_row(key_map[r*ScanCols +: ScanCols]);
    end
  endtask

  // Every sample yields exactly one result, so an empty prediction queue with
  // valid low means the block is idle; extra edges are waited out as margin.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write. The enable is lowered after the edge that takes the write, so two writes in
  // a row never touch cfg_we_i twice in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Next key map of a slowly changing keypad: mostly unchanged, sometimes a
  // few keys toggle, now and then a fresh random map.
  function automatic logic [KeyFieldW-1:0] next_map(logic [KeyFieldW-1:0] cur_map,
                                                     int keep_pct);
    logic [KeyFieldW-1:0] m;
    int r;
    m = cur_map;
    r = $urandom_range(0, 99);
    if (r < keep_pct) return m;
    if (r < keep_pct + (100 - keep_pct) / 2) begin
      repeat ($urandom_range(1, 3)) m[$urandom_range(0, KeyCount - 1)] ^= 1'b1;
      return m;
    end
    return KeyFieldW'($urandom);
  endfunction

  // One configuration setting followed by a run of scans. The upper byte of
  // the limit write is random, since only the low byte belongs to the register.
  task automatic run_phase(input logic [EnableW-1:0] enable, input logic [HoldW-1:0] limit,
                           input int scans, input int keep_pct, input logic no_idle,
                           inout logic [KeyFieldW-1:0] key_map);
    wait_idle();
    write_reg(CfgHoldEnable, enable);
    write_reg(CfgHoldLimit, {8'($urandom), limit});
    if ($urandom_range(0, 3) == 0) write_reg(CfgSpareLo, 16'($urandom));
    if ($urandom_range(0, 3) == 0) write_reg(CfgSpareHi, 16'($urandom));
    calm <= no_idle;
    repeat (scans) begin
      key_map = next_map(key_map, keep_pct);
      send_scan(key_map);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [KeyFieldW-1:0] key_map;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    row_columns_i = '0;
    out_stall_i   = 1'b0;
    calm          = 1'b0;
    stall_run     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset configuration first: all keys down, then all up,
    // which must report every key as released, then a diagonal pattern.
    send_scan(16'hFFFF);
    send_scan(16'h0000);
    send_scan(16'h8421);

    // Limit zero with every key enabled: a key held for one more scan
    // already passes the limit and repeats on every scan after that.
    wait_idle();
    write_reg(CfgHoldEnable, 16'hFFFF);
    write_reg(CfgHoldLimit, 16'h0000);
    send_scan(16'hFFFF);
    send_scan(16'hFFFF);
    send_scan(16'hFFFF);

    // Limit 255 never fires, since the count wraps first. Writes to unused
    // indexes must not disturb either register.
    wait_idle();
    write_reg(CfgHoldLimit, 16'hFFFF);
    write_reg(CfgSpareLo, 16'h0000);
    write_reg(CfgSpareHi, 16'h00FF);
    send_scan(16'hFFFF);
    send_scan(16'h5AA5);

    // Random part: settings from the extremes to the middle of the range.
    key_map = 16'h5AA5;
    run_phase(16'hFFFF, 8'd0, 10, 70, 1'b0, key_map);
    run_phase(EnableW'($urandom), 8'd1, 12, 80, 1'b0, key_map);
    run_phase(EnableW'($urandom), 8'd3, 12, 85, 1'b1, key_map);
    run_phase(16'h0000, 8'd2, 8, 60, 1'b0, key_map);
    run_phase(EnableW'($urandom), HoldLimitReset, 30, 95, 1'b0, key_map);
    run_phase(16'hFFFF, 8'd255, 10, 90, 1'b0, key_map);
    run_phase(EnableW'($urandom), HoldW'($urandom_range(0, 10)), 12, 75, 1'b0, key_map);

    // A large limit: a map held long enough to pass it.
    key_map = KeyFieldW'($urandom) | 16'h0001;
    run_phase(16'hFFFF, 8'd64, 0, 100, 1'b0, key_map);
    repeat (70) send_scan(key_map);

    // Drain, then give any stray result time to show up before the verdict.
    wait_idle();
    repeat (4) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("keypad_matrix_scanner_unit_tb: done, clean");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d expected results never arrived", $time,
                                      sb.pending());
      $display("keypad_matrix_scanner_unit_tb: done, errors");
    end
    $finish;
  end

endmodule : keypad_matrix_scanner_unit_tb

`default_nettype wire

// File: sim.f
src/kms_pkg.sv
src/kms_hold_lane.sv
src/keypad_matrix_scanner_unit.sv
test/keypad_matrix_scanner_unit_tb.sv
